// ===== src/vld_pkg.sv =====
// ----------------------------------------------------------------------------
// vld_pkg - shared types and constants for the varint length deframer
// Field widths, reset values and the result item layout.
// ----------------------------------------------------------------------------
package vld_pkg;

   localparam int BYTE_W          = 8;
   localparam int MSG_LEN_W       = 29;
   localparam int LENGTH_BITS_DEF = 29;

   localparam logic [MSG_LEN_W-1:0] MAX_SIZE_RESET = 29'd16777216;

   // Prefix byte positions
   localparam logic [1:0] PFX_FIRST  = 2'd0;
   localparam logic [1:0] PFX_SECOND = 2'd1;
   localparam logic [1:0] PFX_THIRD  = 2'd2;
   localparam logic [1:0] PFX_FOURTH = 2'd3;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_ERROR   = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type               result_kind;
      logic [BYTE_W-1:0]      payload_byte;
      logic                   last_of_message;
      logic [MSG_LEN_W-1:0]   message_length;
   } rsp_item_type;

   typedef struct packed {
      logic         has_result;
      rsp_item_type item;
   } step_out_type;

endpackage

// ===== src/vld_req_if.sv =====
// ----------------------------------------------------------------------------
// vld_req_if - received byte channel
// valid/ready handshake carrying one link byte per item.
// ----------------------------------------------------------------------------
interface vld_req_if;

   logic                       valid;
   logic                       ready;
   logic [vld_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);

endinterface

// ===== src/vld_rsp_if.sv =====
// ----------------------------------------------------------------------------
// vld_rsp_if - result channel
// valid/ready handshake carrying payload bytes and error items.
// ----------------------------------------------------------------------------
interface vld_rsp_if;

   logic                          valid;
   logic                          ready;
   logic                          result_kind;
   logic [vld_pkg::BYTE_W-1:0]    payload_byte;
   logic                          last_of_message;
   logic [vld_pkg::MSG_LEN_W-1:0] message_length;

   modport source (output valid, output result_kind, output payload_byte,
                   output last_of_message, output message_length, input ready);
   modport sink   (input valid, input result_kind, input payload_byte,
                   input last_of_message, input message_length, output ready);

endinterface

// ===== src/vld_csr_if.sv =====
// ----------------------------------------------------------------------------
// vld_csr_if - limit register write channel
// valid/ready handshake carrying the maximum message size.
// ----------------------------------------------------------------------------
interface vld_csr_if;

   logic                          valid;
   logic                          ready;
   logic [vld_pkg::MSG_LEN_W-1:0] max_message_size;

   modport source (output valid, output max_message_size, input ready);
   modport sink   (input valid, input max_message_size, output ready);

endinterface

// ===== src/vld_step.sv =====
// ----------------------------------------------------------------------------
// vld_step - deframer state and per-byte decode
// Holds the prefix/payload state; decodes one byte per fire.
// ----------------------------------------------------------------------------
module vld_step #(
   parameter int LENGTH_BITS = vld_pkg::LENGTH_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  logic [vld_pkg::BYTE_W-1:0]    rx_byte,
   input  logic [vld_pkg::MSG_LEN_W-1:0] max_size,
   output vld_pkg::step_out_type         step_out
);

   localparam int LW = vld_pkg::MSG_LEN_W;
   // widest length that still fits LENGTH_BITS
   localparam logic [LW:0] LEN_LIMIT = ((LW+1)'(1) << LENGTH_BITS) - (LW+1)'(1);

   logic                   in_payload_ff, in_payload_in;
   logic                   halted_ff, halted_in;
   logic [1:0]             prefix_index_ff, prefix_index_in;
   logic [LW-1:0]          length_accum_ff, length_accum_in;
   logic [LENGTH_BITS-1:0] remaining_ff, remaining_in;

   logic [LW-1:0]          new_len;
   logic [LENGTH_BITS-1:0] rem_dec;
   logic                   prefix_done;
   logic                   len_bad;

   always_comb begin
      case (prefix_index_ff)
         vld_pkg::PFX_FIRST:  new_len = {22'd0, rx_byte[6:0]};
         vld_pkg::PFX_SECOND: new_len = {15'd0, rx_byte[6:0], length_accum_ff[6:0]};
         vld_pkg::PFX_THIRD:  new_len = {8'd0, rx_byte[6:0], length_accum_ff[13:0]};
         default:             new_len = {rx_byte, length_accum_ff[20:0]};
      endcase
   end

   assign rem_dec     = remaining_ff - LENGTH_BITS'(1);
   assign prefix_done = !rx_byte[7] || (prefix_index_ff == vld_pkg::PFX_FOURTH);
   assign len_bad     = (new_len == '0) || (new_len > max_size)
                        || ({1'b0, new_len} > LEN_LIMIT);

   always_comb begin
      in_payload_in   = in_payload_ff;
      halted_in       = halted_ff;
      prefix_index_in = prefix_index_ff;
      length_accum_in = length_accum_ff;
      remaining_in    = remaining_ff;

      step_out                     = '0;
      step_out.item.result_kind    = vld_pkg::KIND_PAYLOAD;
      step_out.item.message_length = length_accum_ff;

      if (halted_ff) begin
         // dropping everything until reset
      end else if (in_payload_ff) begin
         step_out.has_result           = 1'b1;
         step_out.item.payload_byte    = rx_byte;
         step_out.item.last_of_message = (rem_dec == '0);
         remaining_in                  = rem_dec;
         if (rem_dec == '0) begin
            in_payload_in = 1'b0;
         end
      end else if (prefix_index_ff == vld_pkg::PFX_FIRST && rx_byte == '0) begin
         // keep-alive ping
      end else begin
         length_accum_in = new_len;
         if (!prefix_done) begin
            prefix_index_in = prefix_index_ff + 2'd1;
         end else begin
            prefix_index_in = vld_pkg::PFX_FIRST;
            if (len_bad) begin
               halted_in                    = 1'b1;
               step_out.has_result          = 1'b1;
               step_out.item.result_kind    = vld_pkg::KIND_ERROR;
               step_out.item.message_length = new_len;
            end else begin
               in_payload_in = 1'b1;
               remaining_in  = new_len[LENGTH_BITS-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_payload_ff   <= 1'b0;
         halted_ff       <= 1'b0;
         prefix_index_ff <= vld_pkg::PFX_FIRST;
         length_accum_ff <= '0;
         remaining_ff    <= '0;
      end else if (fire) begin
         in_payload_ff   <= in_payload_in;
         halted_ff       <= halted_in;
         prefix_index_ff <= prefix_index_in;
         length_accum_ff <= length_accum_in;
         remaining_ff    <= remaining_in;
      end
   end

endmodule

// ===== src/varint_length_deframer.sv =====
// ----------------------------------------------------------------------------
// varint_length_deframer - splits a byte stream into length-prefixed messages
// Path: a byte is held in the input register, decoded, and its result is
//   registered in the result register, from which the sink takes it.
// Throughput: one byte per cycle; a full result register that is not drained
//   holds back only a byte that makes a result. Reset: synchronous, active
//   high; state cleared, limit back to 16 MiB.
// ----------------------------------------------------------------------------
module varint_length_deframer #(
   parameter int LENGTH_BITS = vld_pkg::LENGTH_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   vld_req_if.sink    req_ch,
   vld_rsp_if.source  rsp_ch,
   vld_csr_if.sink    csr_ch
);

   // Limit register, always ready; user writes it only when idle, unenforced.
   logic [vld_pkg::MSG_LEN_W-1:0] max_size_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_size_ff <= vld_pkg::MAX_SIZE_RESET;
      end else if (csr_ch.valid) begin
         max_size_ff <= csr_ch.max_message_size;
      end
   end

   // Input register: holds one received byte ahead of the decode.
   logic                       in_valid_ff, in_valid_in;
   logic [vld_pkg::BYTE_W-1:0] in_byte_ff;

   // Result register
   logic                  rsp_valid_ff, rsp_valid_in;
   vld_pkg::rsp_item_type rsp_item_ff;

   vld_pkg::step_out_type step_out;
   logic                  out_room;
   logic                  s1_fire;

   // The result register can take a new item when empty or being drained.
   assign out_room = !rsp_valid_ff || rsp_ch.ready;
   // Bytes with no result (prefix, ping, halted) never wait on the output.
   assign s1_fire  = in_valid_ff && (!step_out.has_result || out_room);

   assign req_ch.ready = !in_valid_ff || s1_fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ch.valid && req_ch.ready) begin
         in_valid_in = 1'b1;
      end else if (s1_fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.rx_byte;
      end
   end

   vld_step #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_step (
      .clock    (clock),
      .reset    (reset),
      .fire     (s1_fire),
      .rx_byte  (in_byte_ff),
      .max_size (max_size_ff),
      .step_out (step_out)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire && step_out.has_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && step_out.has_result) begin
         rsp_item_ff <= step_out.item;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.result_kind     = rsp_item_ff.result_kind;
   assign rsp_ch.payload_byte    = rsp_item_ff.payload_byte;
   assign rsp_ch.last_of_message = rsp_item_ff.last_of_message;
   assign rsp_ch.message_length  = rsp_item_ff.message_length;

endmodule
